// File: hw/rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// CIGAR reference-to-read position package
// Shared field widths, operation codes and item types for the mapping unit.
// ----------------------------------------------------------------------------
package crp_pkg;

    // Default sizing of the running registers and of the used op length bits.
    localparam int POSITION_BITS_DEF  = 32;
    localparam int OP_LENGTH_BITS_DEF = 28;

    // Fixed field widths of the stream payload.
    localparam int POS_W     = 31;
    localparam int OP_CODE_W = 4;
    localparam int OP_LEN_W  = 28;

    // Input stream packing, from the lowest bit up.
    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 32;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_OP    = 1'b1;

    // CIGAR operation codes.
    typedef enum logic [OP_CODE_W-1:0] {
        OP_M  = 4'd0,
        OP_I  = 4'd1,
        OP_D  = 4'd2,
        OP_N  = 4'd3,
        OP_S  = 4'd4,
        OP_H  = 4'd5,
        OP_P  = 4'd6,
        OP_EQ = 4'd7,
        OP_X  = 4'd8
    } crp_op_t;

    // One unpacked input item.
    typedef struct packed {
        logic                 req_type;
        logic [POS_W-1:0]     ref_position;
        logic [POS_W-1:0]     align_start;
        logic                 narrow_to_left;
        logic [OP_CODE_W-1:0] op_code;
        logic [OP_LEN_W-1:0]  op_length;
        logic                 last_op;
    } crp_item_t;

    // One result item.
    typedef struct packed {
        logic [POS_W-1:0] read_position;
        logic             mapped_ok;
    } crp_result_t;

    // Control passed from the top level down to the stages.
    typedef struct packed {
        logic advance;   // the held item is consumed this cycle
        logic out_load;  // the held item writes the result register
    } crp_ctl_t;

endpackage

// File: hw/rtl/crp_in_stage.sv
// ----------------------------------------------------------------------------
// CIGAR mapping input stage
// Registers one input transfer and unpacks the stream payload into an item.
// ----------------------------------------------------------------------------
module crp_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [crp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    input  crp_pkg::crp_ctl_t             ctl,
    output crp_pkg::crp_item_t            item,
    output logic                          item_valid
);
    import crp_pkg::*;

    crp_item_t item_reg, item_next;
    logic      valid_reg, valid_next;
    logic      load;

    // The register takes a new transfer when empty or when its item leaves.
    assign s_tready = !valid_reg || ctl.advance;
    assign load     = s_tvalid && s_tready;

    // Unpack the payload: tdata holds the position and op fields.
    always_comb begin
        item_next                = item_reg;
        valid_next               = valid_reg;
        if (load) begin
            item_next.req_type       = s_tuser;
            item_next.ref_position   = s_tdata[30:0];
            item_next.align_start    = s_tdata[61:31];
            item_next.narrow_to_left = s_tdata[62];
            item_next.op_code        = s_tdata[66:63];
            item_next.op_length      = s_tdata[94:67];
            item_next.last_op        = s_tlast;
            valid_next               = 1'b1;
        end else if (ctl.advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

// File: hw/rtl/crp_walker.sv
// ----------------------------------------------------------------------------
// CIGAR mapping walker
// Holds the running target and consumed counts and applies one item a cycle while items advance.
// ----------------------------------------------------------------------------
module crp_walker #(
    parameter int POSITION_BITS  = crp_pkg::POSITION_BITS_DEF,
    parameter int OP_LENGTH_BITS = crp_pkg::OP_LENGTH_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  crp_pkg::crp_item_t   item,
    input  crp_pkg::crp_ctl_t    ctl,
    output crp_pkg::crp_result_t result
);
    import crp_pkg::*;

    // Signed state width and a wider working width for sums and differences.
    localparam int SW   = POSITION_BITS + 2;
    localparam int CW   = (SW > 33 ? SW : 33) + 2;
    localparam int ULEN = (OP_LENGTH_BITS < OP_LEN_W) ? OP_LENGTH_BITS : OP_LEN_W;

    localparam logic signed [CW-1:0] SMAX = $signed({{(CW-SW+1){1'b0}}, {(SW-1){1'b1}}});
    localparam logic signed [CW-1:0] SMIN = $signed({{(CW-SW+1){1'b1}}, {(SW-1){1'b0}}});
    localparam logic signed [CW-1:0] OUT_MAX = $signed({{(CW-POS_W){1'b0}}, {POS_W{1'b1}}});
    localparam logic signed [CW-1:0] ONE = $signed({{(CW-1){1'b0}}, 1'b1});

    logic signed [SW-1:0] target_reg, target_next;
    logic signed [SW-1:0] consumed_reg, consumed_next;
    logic                 reached_reg, reached_next;
    logic                 narrow_reg, narrow_next;

    logic signed [CW-1:0] t_ext, c_ext, len_ext, rp_ext, as_ext, t_new_ext;
    logic                 ok;

    // Saturate a working value to the signed state range.
    function automatic logic signed [SW-1:0] clamp_state(input logic signed [CW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > SMAX) begin
            r = SMAX[SW-1:0];
        end else if (v < SMIN) begin
            r = SMIN[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    assign t_ext   = $signed({{(CW-SW){target_reg[SW-1]}}, target_reg});
    assign c_ext   = $signed({{(CW-SW){consumed_reg[SW-1]}}, consumed_reg});
    assign len_ext = $signed({{(CW-ULEN){1'b0}}, item.op_length[ULEN-1:0]});
    assign rp_ext  = $signed({{(CW-POS_W){1'b0}}, item.ref_position});
    assign as_ext  = $signed({{(CW-POS_W){1'b0}}, item.align_start});

    // Next state for the held item.
    always_comb begin
        target_next   = target_reg;
        consumed_next = consumed_reg;
        narrow_next   = narrow_reg;
        reached_next  = reached_reg;
        if (item.req_type == REQ_START) begin
            target_next   = clamp_state(rp_ext - as_ext + ONE);
            consumed_next = '0;
            narrow_next   = item.narrow_to_left;
            reached_next  = (clamp_state(rp_ext - as_ext + ONE) <= $signed({SW{1'b0}}));
        end else if (!reached_reg) begin
            unique case (item.op_code)
                OP_M, OP_EQ, OP_X: begin
                    consumed_next = clamp_state(c_ext + len_ext);
                end
                OP_I, OP_S: begin
                    target_next   = clamp_state(t_ext + len_ext);
                    consumed_next = clamp_state(c_ext + len_ext);
                end
                OP_D, OP_N: begin
                    if (t_ext - c_ext > len_ext) begin
                        target_next = clamp_state(t_ext - len_ext);
                    end else if (narrow_reg) begin
                        target_next = consumed_reg;
                    end else begin
                        target_next = clamp_state(c_ext + ONE);
                    end
                end
                default: begin
                    // Hard clip, pad and unknown codes leave the state alone.
                end
            endcase
            reached_next = (consumed_next >= target_next);
        end
    end

    // Result for a last op, taken from the updated state.
    assign t_new_ext = $signed({{(CW-SW){target_next[SW-1]}}, target_next});
    assign ok = reached_next && (t_new_ext > $signed({CW{1'b0}})) && (t_new_ext <= OUT_MAX);

    always_comb begin
        result.mapped_ok     = ok;
        result.read_position = ok ? t_new_ext[POS_W-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            consumed_reg <= '0;
            reached_reg  <= 1'b0;
            narrow_reg   <= 1'b0;
        end else if (ctl.advance) begin
            target_reg   <= target_next;
            consumed_reg <= consumed_next;
            reached_reg  <= reached_next;
            narrow_reg   <= narrow_next;
        end
    end

endmodule

// File: hw/rtl/crp_out_stage.sv
// ----------------------------------------------------------------------------
// CIGAR mapping output stage
// Result register that holds one result transfer until the sink takes it.
// ----------------------------------------------------------------------------
module crp_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  crp_pkg::crp_ctl_t             ctl,
    input  crp_pkg::crp_result_t          result,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [crp_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import crp_pkg::*;

    crp_result_t result_reg, result_next;
    logic        valid_reg, valid_next;

    // The register can load when empty or when its result leaves now.
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        result_next = result_reg;
        valid_next  = valid_reg;
        if (ctl.out_load) begin
            result_next = result;
            valid_next  = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        result_reg <= result_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_DATA_W-POS_W){1'b0}}, result_reg.read_position};
    assign m_tuser  = result_reg.mapped_ok;

endmodule

// File: hw/rtl/cigar_reference_to_read_position_unit.sv
// ----------------------------------------------------------------------------
// CIGAR reference-to-read position unit
// Maps a reference position onto a read position by walking CIGAR operations.
// ----------------------------------------------------------------------------
// The unit takes one transfer per clock cycle, start items and op items alike,
// while the result register can take any result. An accepted last op is held
// in the input register and, once it is consumed, its result is registered in
// the result register, which presents it on the output. In the input register
// the running target and consumed counts are updated by one add, compare and
// saturate step; the result register then holds the read position until the
// sink takes it, while further items keep flowing. Only an op item with tlast set gives a result.
module cigar_reference_to_read_position_unit #(
    parameter int POSITION_BITS  = crp_pkg::POSITION_BITS_DEF,
    parameter int OP_LENGTH_BITS = crp_pkg::OP_LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: ref_position[30:0], align_start[61:31], narrow_to_left[62],
    //          op_code[66:63], op_length[94:67], zero fill [95]
    // s_tuser: req_type
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [crp_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    // m_tdata: read_position[30:0], zero fill [31]
    // m_tuser: mapped_ok
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [crp_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser
);
    import crp_pkg::*;

    crp_item_t   item;
    logic        item_valid;
    crp_result_t result;
    crp_ctl_t    ctl;
    logic        out_free;
    logic        gives_result;

    // An item moves on unless its result would find the result register full.
    assign gives_result = (item.req_type == REQ_OP) && item.last_op;
    assign ctl.advance  = item_valid && (!gives_result || out_free);
    assign ctl.out_load = ctl.advance && gives_result;

    crp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .ctl        (ctl),
        .item       (item),
        .item_valid (item_valid)
    );

    crp_walker #(
        .POSITION_BITS  (POSITION_BITS),
        .OP_LENGTH_BITS (OP_LENGTH_BITS)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .ctl     (ctl),
        .result  (result)
    );

    crp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A failed mapping always reports a zero position.
    a_na_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[POS_W-1:0] == '0)
        else $error("NA result carries a nonzero read position");

    // A successful mapping is a positive position.
    a_ok_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[POS_W-1:0] != '0)
        else $error("mapped result has a zero read position");

    // A consumed last op puts a result into the output register.
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.out_load |=> m_tvalid)
        else $error("last op consumed without a pending result");

    // A held item that does not move on stays in the input register.
    a_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        item_valid && !ctl.advance |=> item_valid && $stable(item))
        else $error("input register lost an unconsumed item");

endmodule

// File: test/cigar_reference_to_read_position_unit_test.sv
// ----------------------------------------------------------------------------
// CIGAR reference-to-read position unit testbench
// Streams start and CIGAR op items into the unit, predicts every mapped read
// position in step with the accepted transfers, and checks each result
// transfer in order against the prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module cigar_reference_to_read_position_unit_test;

    import crp_pkg::*;

    // Sizing of the predicted running registers, matching the unit defaults.
    localparam int     STATE_W   = POSITION_BITS_DEF + 2;
    localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint READ_MAX  = 64'sh7FFF_FFFF;

    localparam logic [POS_W-1:0]     POS_MAX = '1;
    localparam logic [OP_LEN_W-1:0]  LEN_MAX = '1;
    localparam logic [OP_CODE_W-1:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [OP_CODE_W-1:0] OP_UNKNOWN_HI = 4'd15;

    localparam int IDLE_MAX     = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int DRAIN_LIMIT  = 5000;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    // Predicted state of the mapping walk.
    logic signed [STATE_W-1:0] map_target;
    logic signed [STATE_W-1:0] map_consumed;
    logic                      map_reached;
    logic                      map_pin_left;

    crp_result_t expected_positions[$];
    int          mismatches;
    int          items_sent;
    bit          pacing_on;

    cigar_reference_to_read_position_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Clamp a running value to the signed range of the unit's registers.
    function automatic longint clamp_running(input longint v);
        if (v > STATE_MAX) return STATE_MAX;
        if (v < STATE_MIN) return STATE_MIN;
        return v;
    endfunction

    // Advance the predicted walk by one accepted item and queue any result.
    task automatic predict_mapping(input crp_item_t item);
        longint      tgt;
        longint      used;
        longint      len;
        bit          ok;
        crp_result_t res;
        tgt  = longint'(map_target);
        used = longint'(map_consumed);
        len  = longint'({36'd0, item.op_length});
        if (item.req_type == REQ_START) begin
            tgt  = clamp_running(longint'({33'd0, item.ref_position})
                                 - longint'({33'd0, item.align_start}) + 1);
            used = 0;
            map_pin_left = item.narrow_to_left;
            map_target   = tgt[STATE_W-1:0];
            map_consumed = used[STATE_W-1:0];
            map_reached  = (used >= tgt);
        end else begin
            // Ops only move the walk while the target is still ahead.
            if (!map_reached) begin
                case (item.op_code)
                    OP_M, OP_EQ, OP_X: begin
                        used = clamp_running(used + len);
                    end
                    OP_I, OP_S: begin
                        tgt  = clamp_running(tgt + len);
                        used = clamp_running(used + len);
                    end
                    OP_D, OP_N: begin
                        if (tgt - used > len)
                            tgt = clamp_running(tgt - len);
                        else
                            tgt = clamp_running(used + (map_pin_left ? 0 : 1));
                    end
                    default: ;
                endcase
                map_target   = tgt[STATE_W-1:0];
                map_consumed = used[STATE_W-1:0];
                map_reached  = (used >= tgt);
            end
            if (item.last_op) begin
                ok = map_reached && (tgt > 0) && (tgt <= READ_MAX);
                res.read_position = ok ? tgt[POS_W-1:0] : '0;
                res.mapped_ok     = ok;
                expected_positions.push_back(res);
            end
        end
    endtask

    // Start item; the op fields it carries are noise.
    function automatic crp_item_t make_start(input logic [POS_W-1:0] ref_pos,
                                             input logic [POS_W-1:0] aln_start,
                                             input logic pin_left);
        crp_item_t item;
        item.req_type       = REQ_START;
        item.ref_position   = ref_pos;
        item.align_start    = aln_start;
        item.narrow_to_left = pin_left;
        item.op_code        = OP_CODE_W'($urandom());
        item.op_length      = OP_LEN_W'($urandom());
        item.last_op        = 1'($urandom());
        return item;
    endfunction

    // Op item; the start fields it carries are noise.
    function automatic crp_item_t make_op(input logic [OP_CODE_W-1:0] code,
                                          input logic [OP_LEN_W-1:0] len,
                                          input logic last);
        crp_item_t item;
        item.req_type       = REQ_OP;
        item.ref_position   = POS_W'($urandom());
        item.align_start    = POS_W'($urandom());
        item.narrow_to_left = 1'($urandom());
        item.op_code        = code;
        item.op_length      = len;
        item.last_op        = last;
        return item;
    endfunction

    // Op code mix weighted toward the ones that move the walk.
    function automatic logic [OP_CODE_W-1:0] pick_op_code();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 35) return OP_M;
        if (r < 45) return OP_EQ;
        if (r < 55) return OP_X;
        if (r < 63) return OP_I;
        if (r < 71) return OP_S;
        if (r < 79) return OP_D;
        if (r < 87) return OP_N;
        if (r < 91) return OP_H;
        if (r < 95) return OP_P;
        return OP_CODE_W'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
    endfunction

    // One input transfer; called and left just after a falling edge.
    task automatic send_item(input crp_item_t item);
        int unsigned gap;
        gap = pacing_on ? $urandom_range(IDLE_MAX, 0) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, item.op_length, item.op_code, item.narrow_to_left,
                     item.align_start, item.ref_position};
        s_tuser  <= item.req_type;
        s_tlast  <= item.last_op;
        do @(posedge aclk); while (!s_tready);
        predict_mapping(item);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Result sink: a random stall before each result transfer while pacing is on.
    initial begin
        int unsigned stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = pacing_on ? $urandom_range(IDLE_MAX, 0) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin : result_check
        crp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_positions.size() == 0) begin
                report_mismatch($sformatf("unexpected result pos=%0d ok=%0b",
                                          m_tdata[POS_W-1:0], m_tuser));
            end else begin
                want = expected_positions.pop_front();
                if (m_tdata[POS_W-1:0] !== want.read_position)
                    report_mismatch($sformatf("read_position %0d, predicted %0d",
                                              m_tdata[POS_W-1:0], want.read_position));
                if (m_tuser !== want.mapped_ok)
                    report_mismatch($sformatf("mapped_ok %0b, predicted %0b",
                                              m_tuser, want.mapped_ok));
            end
        end
    end

    // Ops before any start walk the reset state and never map.
    task automatic test_ops_before_start();
        pacing_on = 1'b0;
        send_item(make_op(OP_M, 28'd5, 1'b1));
    endtask

    // Match ops, with the target hit exactly on the last one.
    task automatic test_match_ops();
        pacing_on = 1'b1;
        send_item(make_start(31'd10, 31'd1, 1'b0));
        send_item(make_op(OP_M, 28'd4, 1'b0));
        send_item(make_op(OP_EQ, 28'd3, 1'b0));
        send_item(make_op(OP_X, 28'd3, 1'b1));
    endtask

    // Insert and soft clip shift the target; ops after the hit do nothing.
    task automatic test_insert_and_clip();
        pacing_on = 1'b0;
        send_item(make_start(31'd20, 31'd11, 1'b0));
        send_item(make_op(OP_S, 28'd2, 1'b0));
        send_item(make_op(OP_I, 28'd3, 1'b0));
        send_item(make_op(OP_M, 28'd10, 1'b0));
        send_item(make_op(OP_M, 28'd1, 1'b1));
    endtask

    // Deletion beyond the target, a gap hit pinned left, then one pinned
    // right that leaves the ops exhausted before the target.
    task automatic test_gap_ops();
        pacing_on = 1'b1;
        send_item(make_start(31'd30, 31'd21, 1'b1));
        send_item(make_op(OP_M, 28'd4, 1'b0));
        send_item(make_op(OP_D, 28'd3, 1'b0));
        send_item(make_op(OP_N, 28'd5, 1'b1));
        send_item(make_start(31'd30, 31'd21, 1'b0));
        send_item(make_op(OP_M, 28'd4, 1'b0));
        send_item(make_op(OP_N, 28'd6, 1'b1));
    endtask

    // Hard clip, pad, unknown codes and zero length leave the walk alone;
    // a further last op without a new start maps from the kept state.
    task automatic test_ignored_ops();
        pacing_on = 1'b1;
        send_item(make_start(POS_MAX, POS_MAX, 1'b0));
        send_item(make_op(OP_H, LEN_MAX, 1'b0));
        send_item(make_op(OP_P, 28'd7, 1'b0));
        send_item(make_op(OP_UNKNOWN_LO, 28'd3, 1'b0));
        send_item(make_op(OP_UNKNOWN_HI, LEN_MAX, 1'b0));
        send_item(make_op(OP_M, 28'd0, 1'b0));
        send_item(make_op(OP_M, 28'd1, 1'b1));
        send_item(make_op(OP_M, 28'd3, 1'b1));
    endtask

    // Negative target, a start left without ops, and a gap pin to zero.
    task automatic test_invalid_targets();
        pacing_on = 1'b0;
        send_item(make_start(31'd1, POS_MAX, 1'b1));
        send_item(make_op(OP_M, LEN_MAX, 1'b1));
        send_item(make_start(31'd50, 31'd1, 1'b0));
        send_item(make_start(31'd3, 31'd1, 1'b1));
        send_item(make_op(OP_N, LEN_MAX, 1'b1));
    endtask

    // Random mix: mostly well-formed CIGARs, some long ones that cross the
    // 31-bit limit or saturate, plus broken sequences and raw noise.
    task automatic test_random_mappings();
        int          stop_at;
        int unsigned kind;
        int unsigned n_ops;
        longint      aln;
        longint      rpos;
        logic [OP_CODE_W-1:0] code;
        logic [OP_LEN_W-1:0]  len;
        crp_item_t   item;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            pacing_on = ($urandom_range(3, 0) != 0);
            kind = $urandom_range(99, 0);
            if (kind < 70) begin
                // Short CIGAR with small lengths around a nearby target.
                aln  = $urandom_range(32'h7FFF_FF00, 1);
                rpos = aln + $urandom_range(250, 0);
                if ($urandom_range(9, 0) == 0)
                    rpos = aln - $urandom_range(4, 0);
                if (rpos < 1)
                    rpos = 1;
                send_item(make_start(rpos[POS_W-1:0], aln[POS_W-1:0],
                                     1'($urandom())));
                n_ops = $urandom_range(12, 1);
                for (int i = 0; i < n_ops; i++) begin
                    code = pick_op_code();
                    len  = ($urandom_range(15, 0) == 0) ? OP_LEN_W'($urandom())
                                                        : OP_LEN_W'($urandom_range(40, 0));
                    send_item(make_op(code, len, i == n_ops - 1));
                end
            end else if (kind < 82) begin
                // Target near the top of the read range, reached by long ops.
                aln  = $urandom_range(1000, 1);
                rpos = $urandom_range(32'h7FFF_FFFF, 32'h7000_0000);
                send_item(make_start(rpos[POS_W-1:0], aln[POS_W-1:0],
                                     1'($urandom())));
                n_ops = $urandom_range(14, 6);
                for (int i = 0; i < n_ops; i++) begin
                    code = ($urandom_range(4, 0) == 0) ? pick_op_code() : OP_M;
                    len  = OP_LEN_W'($urandom_range(LEN_MAX, LEN_MAX - 28'h0FF_FFFF));
                    send_item(make_op(code, len, i == n_ops - 1));
                end
            end else if (kind < 84) begin
                // Enough inserts to saturate the running target.
                send_item(make_start(POS_MAX, 31'd1, 1'($urandom())));
                for (int i = 0; i < 40; i++)
                    send_item(make_op(($urandom_range(1, 0) != 0) ? OP_I : OP_S,
                                      LEN_MAX, 1'b0));
                send_item(make_op(OP_M, LEN_MAX, 1'b0));
                send_item(make_op(OP_M, LEN_MAX, 1'b1));
            end else if (kind < 92) begin
                // Broken sequences.
                case ($urandom_range(2, 0))
                    0: begin
                        send_item(make_start(POS_W'($urandom()), POS_W'($urandom()),
                                             1'($urandom())));
                    end
                    1: begin
                        n_ops = $urandom_range(3, 1);
                        for (int i = 0; i < n_ops; i++)
                            send_item(make_op(pick_op_code(),
                                              OP_LEN_W'($urandom_range(40, 0)),
                                              i == n_ops - 1));
                    end
                    default: begin
                        aln = $urandom_range(32'h7FFF_FF00, 1);
                        send_item(make_start(POS_W'(aln + $urandom_range(100, 0)),
                                             aln[POS_W-1:0], 1'($urandom())));
                        n_ops = $urandom_range(4, 1);
                        for (int i = 0; i < n_ops; i++)
                            send_item(make_op(pick_op_code(),
                                              OP_LEN_W'($urandom_range(40, 0)), 1'b0));
                    end
                endcase
            end else begin
                // Raw noise on every field.
                n_ops = $urandom_range(4, 1);
                for (int i = 0; i < n_ops; i++) begin
                    item.req_type       = 1'($urandom());
                    item.ref_position   = POS_W'($urandom());
                    item.align_start    = POS_W'($urandom());
                    item.narrow_to_left = 1'($urandom());
                    item.op_code        = OP_CODE_W'($urandom());
                    item.op_length      = OP_LEN_W'($urandom());
                    item.last_op        = 1'($urandom());
                    send_item(item);
                end
            end
        end
    endtask

    // Reset, directed tests, random test, drain and verdict.
    initial begin
        int k;
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = 1'b0;
        s_tlast         = 1'b0;
        map_target      = '0;
        map_consumed    = '0;
        map_reached     = 1'b0;
        map_pin_left    = 1'b0;
        mismatches      = 0;
        items_sent      = 0;
        pacing_on       = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_ops_before_start();
        test_match_ops();
        test_insert_and_clip();
        test_gap_ops();
        test_ignored_ops();
        test_invalid_targets();
        test_random_mappings();
        s_tvalid <= 1'b0;

        // Let every predicted result drain and idle briefly before the verdict.
        for (k = 0; k < DRAIN_LIMIT && expected_positions.size() != 0; k++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (expected_positions.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      expected_positions.size()));

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(20_000_000);
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/crp_pkg.sv
hw/rtl/crp_in_stage.sv
hw/rtl/crp_walker.sv
hw/rtl/crp_out_stage.sv
hw/rtl/cigar_reference_to_read_position_unit.sv
test/cigar_reference_to_read_position_unit_test.sv
